// File: rtl/wsd_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
package wsd_pkg;

    // Result kinds as they appear on the result channel's tuser.
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } result_kind_t;

    // Parser phases, one-hot.
    typedef enum logic [4:0] {
        PH_BYTE0   = 5'b00001,
        PH_BYTE1   = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_KEY     = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } parse_phase_t;

    // Register indexes of the configuration port.
    localparam logic REG_MAX_PAYLOAD = 1'b0;

    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd10485760;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam logic [3:0] EXT_BYTES_16 = 4'd2;
    localparam logic [3:0] EXT_BYTES_64 = 4'd8;
    localparam logic [2:0] KEY_BYTES = 3'd4;

    localparam int OUT_DATA_W = 88;

    // One classified event handed from the parser to the output side.
    typedef struct packed {
        result_kind_t kind;
        logic [7:0]   first_byte;
        logic [7:0]   data;
        logic         last;
        logic         masked;
        logic [63:0]  length;
        logic [31:0]  key;
    } q_entry_t;

    // Parser status seen by the top level.
    typedef struct packed {
        logic halted;
        logic phase_idle;
    } front_status_t;

endpackage

// File: rtl/wsd_front.sv
// Header parser: accepts received bytes and classifies them into queue events.
module wsd_front
    import wsd_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  logic [7:0]    rx_byte,
    input  logic [31:0]   max_payload,
    output logic          push,
    output q_entry_t      push_entry,
    output front_status_t status
);

    parse_phase_t phase_reg, phase_next;
    logic [7:0]   first_reg, first_next;
    logic         masked_reg, masked_next;
    logic [3:0]   ext_left_reg, ext_left_next;
    logic [63:0]  len_reg, len_next;
    logic [31:0]  key_reg, key_next;
    logic [2:0]   key_left_reg, key_left_next;
    logic [63:0]  pay_left_reg, pay_left_next;
    logic         halted_reg, halted_next;
    logic         after_len;
    logic         finish;
    logic         pay_last;
    logic [6:0]   len_code;

    assign len_code = rx_byte[6:0];
    assign pay_last = (pay_left_reg == 64'd1);

    always_comb begin
        phase_next    = phase_reg;
        first_next    = first_reg;
        masked_next   = masked_reg;
        ext_left_next = ext_left_reg;
        len_next      = len_reg;
        key_next      = key_reg;
        key_left_next = key_left_reg;
        pay_left_next = pay_left_reg;
        halted_next   = halted_reg;
        after_len     = 1'b0;
        finish        = 1'b0;
        push          = 1'b0;
        push_entry    = '0;

        if (accept && !halted_reg) begin
            unique case (phase_reg)
                PH_BYTE0: begin
                    first_next = rx_byte;
                    phase_next = PH_BYTE1;
                end
                PH_BYTE1: begin
                    masked_next = rx_byte[7];
                    if (len_code == LEN_CODE_16) begin
                        len_next      = '0;
                        ext_left_next = EXT_BYTES_16;
                        phase_next    = PH_EXTLEN;
                    end else if (len_code == LEN_CODE_64) begin
                        len_next      = '0;
                        ext_left_next = EXT_BYTES_64;
                        phase_next    = PH_EXTLEN;
                    end else begin
                        len_next  = {57'd0, len_code};
                        after_len = 1'b1;
                    end
                end
                PH_EXTLEN: begin
                    len_next      = {len_reg[55:0], rx_byte};
                    ext_left_next = ext_left_reg - 4'd1;
                    after_len     = (ext_left_reg == 4'd1);
                end
                PH_KEY: begin
                    key_next      = {key_reg[23:0], rx_byte};
                    key_left_next = key_left_reg - 3'd1;
                    finish        = (key_left_reg == 3'd1);
                end
                PH_PAYLOAD: begin
                    pay_left_next = pay_left_reg - 64'd1;
                    if (pay_last) begin
                        phase_next = PH_BYTE0;
                    end
                    push       = 1'b1;
                    push_entry = '{kind: KIND_PAYLOAD, first_byte: first_reg, data: rx_byte,
                                   last: pay_last, masked: masked_reg, length: len_reg,
                                   key: key_reg};
                end
                default: begin
                    phase_next = PH_BYTE0;
                end
            endcase

            // Length complete: a masked frame still needs its four key bytes.
            if (after_len) begin
                if (masked_next) begin
                    key_left_next = KEY_BYTES;
                    phase_next    = PH_KEY;
                end else begin
                    finish = 1'b1;
                end
            end

            if (finish) begin
                push = 1'b1;
                push_entry = '{kind: KIND_HEADER, first_byte: first_next, data: 8'd0,
                               last: 1'b0, masked: masked_next, length: len_next,
                               key: key_next};
                if (len_next > {32'd0, max_payload}) begin
                    push_entry.kind = KIND_ERROR;
                    halted_next     = 1'b1;
                    phase_next      = PH_BYTE0;
                end else if (len_next == 64'd0) begin
                    push_entry.last = 1'b1;
                    phase_next      = PH_BYTE0;
                end else begin
                    pay_left_next = len_next;
                    phase_next    = PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_BYTE0;
            first_reg    <= '0;
            masked_reg   <= 1'b0;
            ext_left_reg <= '0;
            len_reg      <= '0;
            key_reg      <= '0;
            key_left_reg <= '0;
            pay_left_reg <= '0;
            halted_reg   <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            first_reg    <= first_next;
            masked_reg   <= masked_next;
            ext_left_reg <= ext_left_next;
            len_reg      <= len_next;
            key_reg      <= key_next;
            key_left_reg <= key_left_next;
            pay_left_reg <= pay_left_next;
            halted_reg   <= halted_next;
        end
    end

    assign status.halted     = halted_reg;
    assign status.phase_idle = (phase_reg == PH_BYTE0);

endmodule

// File: rtl/wsd_queue.sv
// Small register queue between the parser and the output stage.
module wsd_queue
    import wsd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     in_ready,
    input  logic     pop,
    output logic     out_valid,
    output q_entry_t head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    q_entry_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign in_ready   = (count_reg != FULL_CNT);
    assign out_valid  = (count_reg != '0);
    assign head_entry = entry_reg[rd_ptr_reg];
    assign do_push    = push && in_ready;
    assign do_pop     = pop && out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/wsd_back.sv
// Output stage: unmasks payload bytes and drives the registered result channel.
module wsd_back
    import wsd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  q_entry_t              q_entry,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    logic                  valid_reg;
    logic [OUT_DATA_W-1:0] data_reg, data_next;
    logic [1:0]            kind_reg;
    logic                  last_reg;
    logic [31:0]           key_reg, key_next;
    logic [1:0]            idx_reg, idx_next;
    logic [7:0]            key_byte;
    logic [7:0]            out_byte;

    assign q_pop = q_valid && (!valid_reg || m_tready);

    // Key bytes are used first byte first, the first one in bits 31..24.
    always_comb begin
        case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        key_next = key_reg;
        idx_next = idx_reg;
        out_byte = 8'd0;
        if (q_entry.kind == KIND_PAYLOAD) begin
            out_byte = q_entry.masked ? (q_entry.data ^ key_byte) : q_entry.data;
            idx_next = idx_reg + 2'd1;
        end else begin
            key_next = q_entry.key;
            idx_next = 2'd0;
        end
        data_next = {7'd0, out_byte, q_entry.length, q_entry.masked,
                     q_entry.first_byte[6:4], q_entry.first_byte[7],
                     q_entry.first_byte[3:0]};
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            data_reg <= data_next;
            kind_reg <= q_entry.kind;
            last_reg <= q_entry.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            key_reg   <= '0;
            idx_reg   <= '0;
        end else begin
            if (q_pop) begin
                valid_reg <= 1'b1;
                key_reg   <= key_next;
                idx_reg   <= idx_next;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

// File: rtl/websocket_frame_deframer_top.sv
// Top level of the WebSocket frame deframer: ports, configuration register, assertions.
//
// The block takes a received WebSocket byte stream, one byte per transaction, and
// parses the frame header (two bytes, an optional 16-bit or 64-bit big-endian
// extended length, an optional 4-byte masking key). When the header is complete it
// sends one header result; every payload byte then yields one result with the byte
// unmasked, and the last payload byte carries tlast. A frame of zero length marks
// its header result with tlast. A frame longer than max_payload_length (register 0,
// byte address 0, reset value 10485760) yields a single error result, after which
// every byte is accepted and dropped until reset. Header bytes before the one that
// completes the header cause no result. The block accepts one byte per cycle while
// the queue has room: the parser updates its state on each accepted byte and pushes
// each result into a small queue (QUEUE_DEPTH entries), and a registered output
// stage drains it one result per cycle while the master side accepts. A result
// passes the queue's entry register and the output register. s_tready falls only
// while the queue is full, which happens once the master side has stalled long enough
// to fill it. Configuration writes are meant for times when no frame is in flight.
module websocket_frame_deframer_top
    import wsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input channel, tdata: rx_byte[7:0].
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    // Result channel, tdata from bit 0 up: opcode[3:0], fin[4], reserved_bits[7:5],
    // masked[8], frame_length[72:9], payload_byte[80:73], zero fill[87:81].
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    // tuser: result_kind[1:0].
    output logic [1:0]            m_tuser,
    // tlast: last_of_frame.
    output logic                  m_tlast,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [31:0]   max_payload_reg;
    logic          cfg_write;
    logic          s_accept;
    logic          q_ready;
    logic          q_valid;
    logic          q_pop;
    logic          front_push;
    q_entry_t      front_entry;
    q_entry_t      head_entry;
    front_status_t front_status;

    // The APB port never inserts wait states. Registers sit at word addresses,
    // so address bit 2 selects the register and the low two bits are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end else if (cfg_write && (paddr[2] == REG_MAX_PAYLOAD)) begin
            max_payload_reg <= pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_MAX_PAYLOAD) ? max_payload_reg : 32'd0;

    // A byte is taken whenever the queue has room, also after an error, when
    // bytes are simply dropped.
    assign s_tready = q_ready;
    assign s_accept = s_tvalid && s_tready;

    wsd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_accept),
        .rx_byte     (s_tdata),
        .max_payload (max_payload_reg),
        .push        (front_push),
        .push_entry  (front_entry),
        .status      (front_status)
    );

    wsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (front_push),
        .push_entry (front_entry),
        .in_ready   (q_ready),
        .pop        (q_pop),
        .out_valid  (q_valid),
        .head_entry (head_entry)
    );

    wsd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (head_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // The parser pushes only on an accepted byte, so the queue always has room.
    assert property (@(posedge aclk) disable iff (!aresetn)
        front_push |-> q_ready)
        else $error("parser pushed into a full queue");

    // An error result on the output implies the parser has halted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_ERROR)) |-> front_status.halted)
        else $error("error result without halted parser");

    // Once halted, the parser stays halted and idle until reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        front_status.halted |=> (front_status.halted && front_status.phase_idle))
        else $error("parser left the halted state");
`endif

endmodule
